@@ rtl/assert_macros.svh @@
// assertion macros used by the track jump distance block
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle as its condition
`define TJD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define TJD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tjd_pkg.sv @@
// types shared by the track jump distance block
// no dependencies
`default_nettype none

package tjd_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_ROOT,
    ST_DONE
  } tjd_state_e;

endpackage

`default_nettype wire

@@ rtl/track_jump_distance.sv @@
// track jump distance: floor euclidean step between consecutive molecules of a trace
// depends on tjd_pkg and assert_macros.svh
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | first_of_list, trace_id, x_pos, y_pos, state
//  out     | output    | out_valid_o/out_ready_i| jump_trace, jump_length, jump_state
//
// a molecule that gives no jump is only stored and gives no output; for a jump, one
// shared multiplier squares dx then dy, one add forms the radicand, and a restoring
// square root unit resolves one result bit per cycle.
// reset clears the stored molecule and the sequencer; there is no clearing pass.
// the finished jump sits in an output register, so the next molecule is taken while
// it waits; the sequencer holds in its final state only if that register is still full.
`default_nettype none

`include "assert_macros.svh"

module track_jump_distance import tjd_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int TRACE_BITS = 16,
  parameter int STATE_BITS = 4
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire                           first_of_list_i,
  input  wire        [TRACE_BITS-1:0]   trace_id_i,
  input  wire signed [COORD_BITS-1:0]   x_pos_i,
  input  wire signed [COORD_BITS-1:0]   y_pos_i,
  input  wire        [STATE_BITS-1:0]   mol_state_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic       [TRACE_BITS-1:0]   jump_trace_o,
  output logic       [COORD_BITS:0]     jump_length_o,
  output logic       [STATE_BITS-1:0]   jump_state_o
);

  localparam int LenBits = COORD_BITS + 1;
  localparam int SqBits  = 2 * COORD_BITS;
  localparam int RadBits = 2 * COORD_BITS + 2;
  localparam int RemBits = COORD_BITS + 2;
  localparam int CntBits = $clog2(COORD_BITS + 1);

  tjd_state_e state_q, state_d;

  // stored previous molecule
  logic                  have_prev_q;
  logic [TRACE_BITS-1:0] prev_trace_q;
  logic [COORD_BITS-1:0] prev_x_q, prev_y_q;

  // working registers
  logic [COORD_BITS-1:0] dx_q, dy_q;
  logic [TRACE_BITS-1:0] trace_q;
  logic [STATE_BITS-1:0] mst_q;
  logic [SqBits-1:0]     prod_q, acc_q;
  logic [RadBits-1:0]    rad_q;
  logic [RemBits-1:0]    rem_q;
  logic [LenBits-1:0]    root_q;
  logic [CntBits-1:0]    cnt_q;

  // output register
  logic                  out_valid_q;
  logic [TRACE_BITS-1:0] out_trace_q;
  logic [LenBits-1:0]    out_len_q;
  logic [STATE_BITS-1:0] out_state_q;

  logic in_fire, match, out_free, last_step, load_out;

  // absolute coordinate differences
  logic [COORD_BITS:0]   diff_x, diff_y;
  logic [COORD_BITS-1:0] abs_x, abs_y;

  assign diff_x = {x_pos_i[COORD_BITS-1], x_pos_i} - {prev_x_q[COORD_BITS-1], prev_x_q};
  assign diff_y = {y_pos_i[COORD_BITS-1], y_pos_i} - {prev_y_q[COORD_BITS-1], prev_y_q};
  assign abs_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
  assign abs_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

  assign in_fire   = in_valid_i && in_ready_o;
  assign match     = have_prev_q && !first_of_list_i && (prev_trace_q == trace_id_i);
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_step = (cnt_q == CntBits'(COORD_BITS));

  // shared squaring multiplier
  logic [COORD_BITS-1:0] mul_op;
  logic [SqBits-1:0]     mul_res;

  assign mul_op  = (state_q == ST_SQX) ? dx_q : dy_q;
  assign mul_res = SqBits'(mul_op) * SqBits'(mul_op);

  // square root step: bring down two radicand bits, try root*4+1
  logic [RemBits+1:0] rem_shift, trial;
  logic               take;

  assign rem_shift = {rem_q, rad_q[RadBits-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign take      = (rem_shift >= trial);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i && match) state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_ROOT;
      ST_ROOT: if (last_step) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_DONE: load_out   = out_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      have_prev_q  <= 1'b0;
      prev_trace_q <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        have_prev_q  <= 1'b1;
        prev_trace_q <= trace_id_i;
        prev_x_q     <= x_pos_i;
        prev_y_q     <= y_pos_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_SUM) begin
        cnt_q <= '0;
      end else if (state_q == ST_ROOT) begin
        cnt_q <= cnt_q + CntBits'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dx_q    <= abs_x;
      dy_q    <= abs_y;
      trace_q <= trace_id_i;
      mst_q   <= mol_state_i;
    end
    unique case (state_q)
      ST_SQX: prod_q <= mul_res;
      ST_SQY: begin
        acc_q  <= prod_q;
        prod_q <= mul_res;
      end
      ST_SUM: begin
        rad_q  <= {1'b0, {1'b0, acc_q} + {1'b0, prod_q}};
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_ROOT: begin
        rad_q <= {rad_q[RadBits-3:0], 2'b00};
        if (take) begin
          rem_q  <= RemBits'(rem_shift - trial);
          root_q <= {root_q[LenBits-2:0], 1'b1};
        end else begin
          rem_q  <= RemBits'(rem_shift);
          root_q <= {root_q[LenBits-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_trace_q <= trace_q;
      out_len_q   <= root_q;
      out_state_q <= mst_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign jump_trace_o  = out_trace_q;
  assign jump_length_o = out_len_q;
  assign jump_state_o  = out_state_q;

  // checks on the sequencer and the root unit
  `TJD_ASSERT(a_root_count, (state_q != ST_ROOT) || (cnt_q <= CntBits'(COORD_BITS)), "root overrun")
  `TJD_ASSERT(a_rem_bound, (state_q != ST_ROOT) || ({1'b0, rem_q} <= {1'b0, root_q, 1'b0}), "remainder too big")
  `TJD_ASSERT_NEXT(a_start_jump, in_fire && match, state_q == ST_SQX, "jump not started")
  `TJD_ASSERT_NEXT(a_deliver, load_out, out_valid_o && (state_q == ST_IDLE), "jump not delivered")

endmodule

`default_nettype wire
